@@ design/terminal_text_sanitizer_assert.svh @@
// Assertion macros for the terminal text sanitizer.
// Used by modules that carry concurrent checks; expects clk and rst in scope.
`ifndef TERMINAL_TEXT_SANITIZER_ASSERT_SVH
`define TERMINAL_TEXT_SANITIZER_ASSERT_SVH

// same-cycle implication
`define TTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/tts_pkg.sv @@
// Shared constants and types for the terminal text sanitizer.
// No dependencies.
`timescale 1ns / 1ps

package tts_pkg;

  localparam int SEQ_DEPTH = 32;
  localparam int SEQ_AW    = 5;
  localparam int CNT_W     = 6;
  localparam int ROOM_W    = 16;

  localparam logic [ROOM_W-1:0] ROOM_RESET = 16'd8182;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_HIGH  = 8'h80;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] PRM_LO   = 8'h30;
  localparam logic [7:0] PRM_HI   = 8'h3F;
  localparam logic [7:0] INT_LO   = 8'h20;
  localparam logic [7:0] INT_HI   = 8'h2F;
  localparam logic [7:0] FIN_LO   = 8'h40;
  localparam logic [7:0] FIN_HI   = 8'h7E;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       text_end;
    logic       run_last;
  } res_item_t;

endpackage

@@ design/tts_seq_ram.sv @@
// Escape sequence byte store: one write port, one read port, registered read.
// Depends on tts_pkg.
`timescale 1ns / 1ps

module tts_seq_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [tts_pkg::SEQ_AW-1:0] waddr,
  input  logic [7:0]                 wdata,
  input  logic [tts_pkg::SEQ_AW-1:0] raddr,
  output logic [7:0]                 rdata
);

  logic [7:0] mem [tts_pkg::SEQ_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/tts_ctrl.sv @@
// Byte scanner and emit sequencer: parses CSI sequences, keeps room count,
// replays a buffered sequence from tts_seq_ram. Depends on tts_pkg, tts_seq_ram.
`timescale 1ns / 1ps

module tts_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_byte,
  input  logic                       in_end,
  input  logic [tts_pkg::ROOM_W-1:0] room,
  input  logic                       dn_ready,
  output tts_pkg::res_item_t         res
);

`include "terminal_text_sanitizer_assert.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DUMP = 2'd1;
  localparam logic [1:0] ST_TERM = 2'd2;

  localparam logic [1:0] M_NORMAL = 2'd0;
  localparam logic [1:0] M_ESC    = 2'd1;
  localparam logic [1:0] M_PARAM  = 2'd2;
  localparam logic [1:0] M_INTER  = 2'd3;

  localparam logic [tts_pkg::CNT_W-1:0] DEPTH_C = tts_pkg::CNT_W'(tts_pkg::SEQ_DEPTH);

  logic [1:0]                 state, state_next;
  logic [1:0]                 mode, mode_next;
  logic [tts_pkg::CNT_W-1:0]  count, count_next;
  logic                       too_long, too_long_next;
  logic [tts_pkg::ROOM_W-1:0] written, written_next;
  logic [tts_pkg::SEQ_AW-1:0] ptr, ptr_next;
  logic [tts_pkg::SEQ_AW-1:0] dump_last, dump_last_next;
  logic                       term_pend, term_pend_next;

  logic                       accept, active, in_seq;
  logic                       is_p, is_i, is_f, brk, run_normal;
  logic                       keep, is_esc, emit_char, append, has_room, fits, start_dump;
  logic [tts_pkg::ROOM_W:0]   seq_total;
  logic                       ram_we;
  logic [tts_pkg::SEQ_AW-1:0] ram_raddr;
  logic [7:0]                 ram_q;

  assign in_ready = (state == ST_IDLE) && dn_ready;
  assign accept   = in_valid && in_ready;
  assign active   = written < room;
  assign in_seq   = (mode == M_PARAM) || (mode == M_INTER);

  assign is_p = (mode == M_PARAM) && (in_byte >= tts_pkg::PRM_LO) && (in_byte <= tts_pkg::PRM_HI);
  assign is_i = (in_byte >= tts_pkg::INT_LO) && (in_byte <= tts_pkg::INT_HI);
  assign is_f = (in_byte >= tts_pkg::FIN_LO) && (in_byte <= tts_pkg::FIN_HI);
  assign brk  = in_seq && !(is_p || is_i || is_f);

  assign run_normal = active && ((mode == M_NORMAL) || brk);
  assign is_esc     = in_byte == tts_pkg::CH_ESC;
  assign keep       = (in_byte < tts_pkg::CH_HIGH) &&
                      (((in_byte >= tts_pkg::INT_LO) && (in_byte <= tts_pkg::FIN_HI)) ||
                       (in_byte == tts_pkg::CH_LF) || (in_byte == tts_pkg::CH_CR) ||
                       (in_byte == tts_pkg::CH_TAB));
  assign emit_char  = run_normal && keep;

  assign append    = active && in_seq && (is_p || is_i || is_f);
  assign has_room  = count < DEPTH_C;
  assign seq_total = {1'b0, written} + (tts_pkg::ROOM_W+1)'(count) +
                     (tts_pkg::ROOM_W+1)'(1);
  assign fits      = seq_total < {1'b0, room};
  assign start_dump = active && in_seq && is_f && !too_long && has_room && fits;

  assign ram_we = accept && append && has_room;

  always_comb begin
    if (state == ST_DUMP) begin
      ram_raddr = dn_ready ? ptr + 1'b1 : ptr;
    end else begin
      ram_raddr = '0;
    end
  end

  tts_seq_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[tts_pkg::SEQ_AW-1:0]),
    .wdata (in_byte),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_comb begin
    state_next     = state;
    mode_next      = mode;
    count_next     = count;
    too_long_next  = too_long;
    written_next   = written;
    ptr_next       = ptr;
    dump_last_next = dump_last;
    term_pend_next = term_pend;
    res            = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (active) begin
            unique case (mode)
              M_ESC: begin
                if (in_byte == tts_pkg::CH_LBRK) begin
                  count_next    = tts_pkg::CNT_W'(2);
                  too_long_next = 1'b0;
                  mode_next     = M_PARAM;
                end else begin
                  mode_next = M_NORMAL;
                end
              end
              M_PARAM, M_INTER: begin
                if (append) begin
                  if (has_room) begin
                    count_next = count + 1'b1;
                  end else begin
                    too_long_next = 1'b1;
                  end
                  if (is_i) begin
                    mode_next = M_INTER;
                  end
                end
                if (is_f || brk) begin
                  count_next    = '0;
                  too_long_next = 1'b0;
                  mode_next     = M_NORMAL;
                end
                if (start_dump) begin
                  written_next   = seq_total[tts_pkg::ROOM_W-1:0];
                  dump_last_next = count[tts_pkg::SEQ_AW-1:0];
                  ptr_next       = '0;
                  term_pend_next = in_end;
                  state_next     = ST_DUMP;
                end
              end
              default: begin
                mode_next = M_NORMAL;
              end
            endcase
            if (run_normal && is_esc) begin
              mode_next = M_ESC;
            end
            if (emit_char) begin
              written_next = written + 1'b1;
            end
          end
          if (in_end) begin
            mode_next     = M_NORMAL;
            count_next    = '0;
            too_long_next = 1'b0;
            written_next  = '0;
            if (emit_char) begin
              state_next = ST_TERM;
            end
          end
          res.valid    = emit_char || (in_end && !start_dump);
          res.data     = emit_char ? in_byte : 8'h00;
          res.text_end = !emit_char;
          res.run_last = emit_char ? !in_end : 1'b1;
        end
      end
      ST_DUMP: begin
        res.valid    = 1'b1;
        res.data     = (ptr == '0) ? tts_pkg::CH_ESC :
                       (ptr == tts_pkg::SEQ_AW'(1)) ? tts_pkg::CH_LBRK : ram_q;
        res.text_end = 1'b0;
        res.run_last = (ptr == dump_last) && !term_pend;
        if (dn_ready) begin
          ptr_next = ptr + 1'b1;
          if (ptr == dump_last) begin
            state_next = term_pend ? ST_TERM : ST_IDLE;
          end
        end
      end
      ST_TERM: begin
        res.valid    = 1'b1;
        res.data     = 8'h00;
        res.text_end = 1'b1;
        res.run_last = 1'b1;
        if (dn_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= M_NORMAL;
      count     <= '0;
      too_long  <= 1'b0;
      written   <= '0;
      ptr       <= '0;
      dump_last <= '0;
      term_pend <= 1'b0;
    end else begin
      state     <= state_next;
      mode      <= mode_next;
      count     <= count_next;
      too_long  <= too_long_next;
      written   <= written_next;
      ptr       <= ptr_next;
      dump_last <= dump_last_next;
      term_pend <= term_pend_next;
    end
  end

  `TTS_ASSERT_IMP(a_no_write_in_dump, ram_we, state == ST_IDLE, "seq store written outside idle")
  `TTS_ASSERT_IMP(a_ptr_in_range, state == ST_DUMP, ptr <= dump_last, "dump pointer overran")
  `TTS_ASSERT_NXT(a_term_clears, res.valid && res.text_end && dn_ready,
                  (written == '0) && (mode == M_NORMAL) && (count == '0),
                  "state not cleared after terminator")
  `TTS_ASSERT_IMP(a_dump_min_len, state == ST_DUMP, dump_last >= tts_pkg::SEQ_AW'(2),
                  "dumped sequence shorter than ESC [ final")

endmodule

@@ design/terminal_text_sanitizer.sv @@
// Terminal text sanitizer top level: config register, scanner and output register.
// Depends on tts_pkg, tts_ctrl, tts_seq_ram.
//
//   port group   dir  contents
//   s_*          in   tdata = in_byte[7:0], tlast = chunk_end
//   m_*          out  tdata = out_byte[7:0], tuser = text_end, tlast = run_last
//   cfg_*        in   cfg_wdata = out_room[15:0], written when cfg_we is high
//
// Bytes with at most one result stream back to back while m_tready keeps up. A whole
// CSI of n bytes is replayed (ESC and [ from constants, the rest from sequence RAM),
// one entry per cycle alike; input stays held until it and any terminator are out.
// One output register; the scanner and the input stall while a result waits on m_tready.
// rst is synchronous; out_room resets to 8182, no clearing pass is needed.
`timescale 1ns / 1ps

module terminal_text_sanitizer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] in_byte
  input  logic                       s_tlast,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,   // [7:0] out_byte
  output logic                       m_tuser,   // [0] text_end
  output logic                       m_tlast,
  input  logic                       cfg_we,
  input  logic [tts_pkg::ROOM_W-1:0] cfg_wdata
);

  logic [tts_pkg::ROOM_W-1:0] out_room;
  logic                       dn_ready;
  tts_pkg::res_item_t         res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_room <= tts_pkg::ROOM_RESET;
    end else if (cfg_we) begin
      out_room <= cfg_wdata;
    end
  end

  assign dn_ready = !m_tvalid || m_tready;

  tts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_end   (s_tlast),
    .room     (out_room),
    .dn_ready (dn_ready),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (dn_ready) begin
      m_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dn_ready && res.valid) begin
      m_tdata <= res.data;
      m_tuser <= res.text_end;
      m_tlast <= res.run_last;
    end
  end

endmodule
